// ===== src/tpjd_pkg.sv =====
// Shared constants and beat codes for the two-level priority job dispatcher.
package tpjd_pkg;

  // Codes of the kind field on the input channel.
  localparam logic [1:0] KIND_SUBMIT   = 2'd0;
  localparam logic [1:0] KIND_FINISH   = 2'd1;
  localparam logic [1:0] KIND_SHUTDOWN = 2'd2;

  // Default sizes of the two job stores and of a job tag.
  localparam int unsigned URGENT_DEPTH_DEF     = 16;
  localparam int unsigned BACKGROUND_DEPTH_DEF = 16;
  localparam int unsigned TAG_BITS_DEF         = 16;

endpackage

// ===== src/tpjd_mem.sv =====
// Single-port-write, single-port-read tag memory with a registered read.
module tpjd_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and read share the edge; a read of the written address returns the old word.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/two_level_priority_job_dispatcher.sv =====
// Top level of the two-level strict-priority job dispatcher for a single worker.
//
//   Channel | Direction | Handshake                | Payload
//   --------+-----------+--------------------------+----------------------------------------
//   in      | input     | in_valid_i / in_ready_o  | kind_i, job_tag_i, high_priority_i
//   out     | output    | out_valid_o / out_ready_i| dispatch_valid_o, dispatched_tag_o,
//           |           |                          | dispatched_from_high_o, dropped_o,
//           |           |                          | worker_busy_o, urgent_level_o,
//           |           |                          | background_level_o
//
// One beat is accepted every cycle while the output does not stall; each input beat yields exactly one output beat.
// Each beat passes through two registers, the input register and the result register,
// the store memories' registered read ports being part of the result register.
// Reset (rst_ni low, asynchronous) empties both stores, frees the worker and clears halt.
// A stall on the output holds the result register and the state; the input register
// still takes one more beat, after which in_ready_o follows out_ready_i.
module two_level_priority_job_dispatcher
  import tpjd_pkg::*;
#(
  parameter int unsigned URGENT_DEPTH     = URGENT_DEPTH_DEF,
  parameter int unsigned BACKGROUND_DEPTH = BACKGROUND_DEPTH_DEF,
  parameter int unsigned TAG_BITS         = TAG_BITS_DEF,
  localparam int unsigned UCW = $clog2(URGENT_DEPTH + 1),
  localparam int unsigned BCW = $clog2(BACKGROUND_DEPTH + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          kind_i,
  input  logic [TAG_BITS-1:0] job_tag_i,
  input  logic                high_priority_i,

  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                dispatch_valid_o,
  output logic [TAG_BITS-1:0] dispatched_tag_o,
  output logic                dispatched_from_high_o,
  output logic                dropped_o,
  output logic                worker_busy_o,
  output logic [UCW-1:0]      urgent_level_o,
  output logic [BCW-1:0]      background_level_o
);

  localparam int unsigned UIW = (URGENT_DEPTH > 1) ? $clog2(URGENT_DEPTH) : 1;
  localparam int unsigned BIW = (BACKGROUND_DEPTH > 1) ? $clog2(BACKGROUND_DEPTH) : 1;
  // Wide enough to hold head plus count before the wrap.
  localparam int unsigned BSW = BCW + 1;

  // ---------------------------------------------------------------------------
  // Input register. It frees up whenever its beat moves on to the result side.
  // ---------------------------------------------------------------------------
  logic                in_valid_q;
  logic [1:0]          kind_q;
  logic [TAG_BITS-1:0] tag_q;
  logic                high_q;
  logic                in_accept;
  logic                advance;

  // The beat in the input register is processed when the result register is
  // empty or is being emptied in this cycle.
  assign advance    = in_valid_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_accept  = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      kind_q <= kind_i;
      tag_q  <= job_tag_i;
      high_q <= high_priority_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Scheduler state. These registers also serve as the status part of the
  // result, since they only change when a new result is loaded.
  // ---------------------------------------------------------------------------
  logic           busy_q,   busy_d;
  logic           halted_q, halted_d;
  logic [UCW-1:0] ucnt_q,   ucnt_d;
  logic [BCW-1:0] bcnt_q,   bcnt_d;
  logic [BIW-1:0] bhead_q,  bhead_d;

  // ---------------------------------------------------------------------------
  // Single-pass update: push first, then dispatch if the worker is free.
  // ---------------------------------------------------------------------------
  logic           running;
  logic           is_submit;
  logic           is_finish;
  logic           is_shutdown;
  logic           push_u;
  logic           push_b;
  logic           drop;
  logic           busy_mid;
  logic [UCW-1:0] ucnt_mid;
  logic [BCW-1:0] bcnt_mid;
  logic           disp_ok;
  logic           pop_u;
  logic           pop_b;
  logic           bypass;
  logic [UCW-1:0] utop;
  logic [BSW-1:0] bslot_sum;
  logic [BSW-1:0] bslot_wrap;
  logic [BIW-1:0] bslot;
  logic [BSW-1:0] bhead_inc;
  logic [BIW-1:0] bhead_next;

  assign running     = !halted_q;
  assign is_submit   = running && (kind_q == KIND_SUBMIT);
  assign is_finish   = running && (kind_q == KIND_FINISH);
  assign is_shutdown = running && (kind_q == KIND_SHUTDOWN);

  assign push_u = is_submit && high_q && (ucnt_q < UCW'(URGENT_DEPTH));
  assign push_b = is_submit && !high_q && (bcnt_q < BCW'(BACKGROUND_DEPTH));
  assign drop   = is_submit && !push_u && !push_b;

  assign busy_mid = is_finish ? 1'b0 : busy_q;
  assign ucnt_mid = ucnt_q + UCW'(push_u);
  assign bcnt_mid = bcnt_q + BCW'(push_b);

  // Urgent work always wins; the background FIFO is served only when the stack is empty.
  assign disp_ok = (is_submit || is_finish) && !busy_mid;
  assign pop_u   = disp_ok && (ucnt_mid != '0);
  assign pop_b   = disp_ok && !pop_u && (bcnt_mid != '0);

  // Stack top after the push.
  assign utop = ucnt_mid - UCW'(1);

  // FIFO tail slot is head plus count, wrapped once at the depth.
  assign bslot_sum  = BSW'(bhead_q) + BSW'(bcnt_q);
  assign bslot_wrap = (bslot_sum >= BSW'(BACKGROUND_DEPTH)) ?
                      (bslot_sum - BSW'(BACKGROUND_DEPTH)) : bslot_sum;
  assign bslot      = bslot_wrap[BIW-1:0];
  assign bhead_inc  = BSW'(bhead_q) + BSW'(1);
  assign bhead_next = (bhead_inc == BSW'(BACKGROUND_DEPTH)) ? '0 : bhead_inc[BIW-1:0];

  // A job that is pushed and dispatched on the same beat never comes back out of
  // the memory in time, so its tag is forwarded around it. On the stack this is
  // any push followed by a pop; on the FIFO only when the FIFO was empty.
  assign bypass = (push_u && pop_u) || (push_b && pop_b && (bcnt_q == '0));

  always_comb begin
    busy_d   = busy_q;
    halted_d = halted_q;
    ucnt_d   = ucnt_q;
    bcnt_d   = bcnt_q;
    bhead_d  = bhead_q;
    if (is_shutdown) begin
      busy_d   = 1'b1;
      halted_d = 1'b1;
      ucnt_d   = '0;
      bcnt_d   = '0;
      bhead_d  = '0;
    end else if (is_submit || is_finish) begin
      busy_d = busy_mid || pop_u || pop_b;
      ucnt_d = pop_u ? utop : ucnt_mid;
      bcnt_d = pop_b ? (bcnt_mid - BCW'(1)) : bcnt_mid;
      if (pop_b) begin
        bhead_d = bhead_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      halted_q <= 1'b0;
      ucnt_q   <= '0;
      bcnt_q   <= '0;
      bhead_q  <= '0;
    end else if (advance) begin
      busy_q   <= busy_d;
      halted_q <= halted_d;
      ucnt_q   <= ucnt_d;
      bcnt_q   <= bcnt_d;
      bhead_q  <= bhead_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Job stores. Their read registers load only when a result is produced, so a
  // stalled result keeps its tag.
  // ---------------------------------------------------------------------------
  logic [TAG_BITS-1:0] urd;
  logic [TAG_BITS-1:0] brd;

  tpjd_mem #(
    .DEPTH (URGENT_DEPTH),
    .WIDTH (TAG_BITS)
  ) u_urgent_mem (
    .clk_i   (clk_i),
    .we_i    (advance && push_u),
    .waddr_i (ucnt_q[UIW-1:0]),
    .wdata_i (tag_q),
    .re_i    (advance && pop_u),
    .raddr_i (utop[UIW-1:0]),
    .rdata_o (urd)
  );

  tpjd_mem #(
    .DEPTH (BACKGROUND_DEPTH),
    .WIDTH (TAG_BITS)
  ) u_background_mem (
    .clk_i   (clk_i),
    .we_i    (advance && push_b),
    .waddr_i (bslot),
    .wdata_i (tag_q),
    .re_i    (advance && pop_b),
    .raddr_i (bhead_q),
    .rdata_o (brd)
  );

  // ---------------------------------------------------------------------------
  // Result register.
  // ---------------------------------------------------------------------------
  logic                out_valid_q;
  logic                disp_q;
  logic                from_high_q;
  logic                dropped_q;
  logic                bypass_q;
  logic [TAG_BITS-1:0] bypass_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      disp_q       <= pop_u || pop_b;
      from_high_q  <= pop_u;
      dropped_q    <= drop;
      bypass_q     <= bypass;
      bypass_tag_q <= tag_q;
    end
  end

  assign out_valid_o            = out_valid_q;
  assign dispatch_valid_o       = disp_q;
  assign dispatched_from_high_o = disp_q && from_high_q;
  assign dropped_o              = dropped_q;
  assign worker_busy_o          = busy_q;
  assign urgent_level_o         = ucnt_q;
  assign background_level_o     = bcnt_q;

  // The tag reads as zero when nothing was dispatched.
  always_comb begin
    dispatched_tag_o = '0;
    if (disp_q) begin
      if (bypass_q) begin
        dispatched_tag_o = bypass_tag_q;
      end else if (from_high_q) begin
        dispatched_tag_o = urd;
      end else begin
        dispatched_tag_o = brd;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------

  // A dispatch always leaves the worker busy.
  a_dispatch_sets_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && dispatch_valid_o) |-> worker_busy_o)
    else $error("dispatch reported with a free worker");

  // Neither count can pass its store's depth.
  a_levels_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ucnt_q <= UCW'(URGENT_DEPTH)) && (bcnt_q <= BCW'(BACKGROUND_DEPTH)))
    else $error("store count beyond depth");

  // Only reset leaves the halted condition.
  a_halt_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("halt released without reset");

  // While halted the stores are empty and the worker reads as busy.
  a_halted_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |-> (busy_q && (ucnt_q == '0) && (bcnt_q == '0)))
    else $error("halted with live jobs or a free worker");

  // A drop happens only when some store is full.
  a_drop_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && dropped_o) |->
      ((ucnt_q == UCW'(URGENT_DEPTH)) || (bcnt_q == BCW'(BACKGROUND_DEPTH))))
    else $error("drop reported with room in both stores");

  // A free worker never sits beside waiting jobs, since every free moment dispatches.
  a_no_idle_with_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy_q) |-> ((ucnt_q == '0) && (bcnt_q == '0)))
    else $error("worker free while jobs wait");

endmodule
